// File: sv/dtv_pkg.sv
// ----------------------------------------------------------------------------
// dtv_pkg: shared types and constants of the drum and tone voice synth
// Voice classes, queue item, configuration bundle, sequencer states and the
// fixed-point constants used by the front and back halves.
// ----------------------------------------------------------------------------
package dtv_pkg;

  localparam int COUNT_BITS       = 22;
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int SINE_ADDR_BITS   = $clog2(SINE_TABLE_DEPTH);
  localparam logic [15:0] SINE_MASK =
    16'(((1 << SINE_ADDR_BITS) - 1) << (16 - SINE_ADDR_BITS));

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [23:0] ENV_FULL         = 24'hFFFFFF;
  localparam logic [23:0] KICK_DECAY       = 24'd16771130;
  localparam logic [23:0] HAT_DECAY        = 24'd16762005;
  localparam logic [23:0] SWEEP_DECAY      = 24'd16774174;
  localparam logic [23:0] TONE_DECAY_RESET = 24'd16775999;

  localparam int ATTACK_LEN     = 441;
  localparam int ATTACK_BITS    = $clog2(ATTACK_LEN);
  localparam int LEVEL_ONE      = 1024;

  localparam logic [14:0] HASH_MUL_LO = 15'd20077;  // low 15 bits of 1103515245
  localparam logic [14:0] HASH_ADD    = 15'd12345;

  // reciprocals: x/5 as (x*OMIX_RECIP)>>26, x/25 as (x*GAIN_RECIP)>>28,
  // x/127 as (x*DIV127_RECIP)>>33, x/441 as (x*ATK_RECIP)>>34 (x below 2^25),
  // exact over the operand ranges used
  localparam logic [23:0] OMIX_RECIP   = 24'd13421773;
  localparam logic [23:0] GAIN_RECIP   = 24'd10737419;
  localparam logic [26:0] DIV127_RECIP = 27'd67637281;
  localparam logic [25:0] ATK_RECIP    = 26'd38956620;
  localparam logic signed [25:0] DIV127_BIAS = 26'sd33292288;  // 127 * 2^18

  typedef enum logic [1:0] {
    REG_REVERENCE   = 2'd0,
    REG_ABSTRACTION = 2'd1,
    REG_TONE_DECAY  = 2'd2
  } reg_index_e;

  typedef enum logic [1:0] {
    VOICE_KICK,
    VOICE_HAT,
    VOICE_TONE
  } voice_e;

  typedef struct packed {
    logic        note_start;
    voice_e      voice;
    logic [30:0] step;
    logic [6:0]  velocity;
  } item_t;

  typedef struct packed {
    logic [10:0] reverence;
    logic [10:0] abstraction;
    logic [23:0] tone_decay;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_GAIN_MUL, ST_GAIN_SET,
    ST_KICK_MUL, ST_KICK_PHASE, ST_KICK_OSC, ST_SWEEP_SET,
    ST_HAT_MUL, ST_HAT_OSC,
    ST_TONE_MIX, ST_TONE_SINE, ST_TONE_OCT,
    ST_TONE_SUM0, ST_TONE_SUM1, ST_TONE_SUM2, ST_TONE_SUM3,
    ST_SIN_SQ, ST_SIN_T1, ST_SIN_T2, ST_SIN_T3, ST_SIN_Y,
    ST_AMP_MUL, ST_AMP_SET, ST_ATK_LOAD, ST_ATK_Q1, ST_ATK_LO, ST_ATK_SET,
    ST_VEL_MUL, ST_OSC_MUL, ST_DIV127, ST_LEFT, ST_RIGHT, ST_OUT
  } seq_state_e;

  function automatic logic [30:0] top_octave_step(input logic [3:0] idx);
    logic [30:0] s;
    case (idx)
      4'd0:    s = 31'd815363807;
      4'd1:    s = 31'd863847866;
      4'd2:    s = 31'd915214890;
      4'd3:    s = 31'd969636443;
      4'd4:    s = 31'd1027293983;
      4'd5:    s = 31'd1088380142;
      4'd6:    s = 31'd1153098581;
      4'd7:    s = 31'd1221665381;
      4'd8:    s = 31'd1294309404;
      4'd9:    s = 31'd1371272980;
      4'd10:   s = 31'd1452813111;
      4'd11:   s = 31'd1539201885;
      default: s = 31'd0;
    endcase
    return s;
  endfunction

  // octave = p/12 by reciprocal (p*43)>>9, exact for 7-bit p
  function automatic logic [30:0] pitch_step(input logic [6:0] p);
    logic [12:0] scaled;
    logic [3:0]  oct;
    logic [6:0]  rem;
    scaled = 13'(p) * 13'd43;
    oct    = scaled[12:9];
    rem    = p - 7'(7'(oct) * 7'd12);
    return top_octave_step(rem[3:0]) >> (4'd10 - oct);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    logic signed [15:0] r;
    if (v > 20'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -20'sd32768) begin
      r = -16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// File: sv/dtv_note_if.sv
// ----------------------------------------------------------------------------
// dtv_note_if: note tick channel
// Valid/ready channel carrying start flag, pitch and velocity of one tick.
// ----------------------------------------------------------------------------
interface dtv_note_if;
  logic       valid;
  logic       ready;
  logic       note_start;
  logic [6:0] pitch;
  logic [6:0] velocity;

  modport source (output valid, note_start, pitch, velocity, input ready);
  modport sink   (input valid, note_start, pitch, velocity, output ready);
endinterface

// File: sv/dtv_sample_if.sv
// ----------------------------------------------------------------------------
// dtv_sample_if: stereo sample channel
// Valid/ready channel carrying one Q1.15 left/right sample pair.
// ----------------------------------------------------------------------------
interface dtv_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;

  modport source (output valid, left_sample, right_sample, input ready);
  modport sink   (input valid, left_sample, right_sample, output ready);
endinterface

// File: sv/dtv_front.sv
// ----------------------------------------------------------------------------
// dtv_front: tick intake and voice classification
// Accepts note ticks, picks kick, hat or tonal voice, looks up the phase
// step and pushes the classified item into the queue.
// ----------------------------------------------------------------------------
module dtv_front (
  dtv_note_if.sink            note_in,
  input  dtv_pkg::queue_stat_t stat_i,
  output logic                push_o,
  output dtv_pkg::item_t      item_o
);
  import dtv_pkg::*;

  voice_e voice;

  assign note_in.ready = !stat_i.full;
  assign push_o        = note_in.valid && !stat_i.full;

  always_comb begin
    if (note_in.pitch < 7'd40) begin
      voice = VOICE_KICK;
    end else if (note_in.pitch == 7'd42 || note_in.pitch == 7'd44 ||
                 note_in.pitch == 7'd46) begin
      voice = VOICE_HAT;
    end else begin
      voice = VOICE_TONE;
    end
  end

  always_comb begin
    item_o.note_start = note_in.note_start;
    item_o.voice      = voice;
    item_o.step       = pitch_step(note_in.pitch);
    item_o.velocity   = note_in.velocity;
  end

endmodule

// File: sv/dtv_queue.sv
// ----------------------------------------------------------------------------
// dtv_queue: item queue between front and back
// Small register FIFO so intake and rendering stall independently.
// ----------------------------------------------------------------------------
module dtv_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  dtv_pkg::item_t       item_i,
  input  logic                 pop_i,
  output dtv_pkg::item_t       item_o,
  output dtv_pkg::queue_stat_t stat_o
);
  import dtv_pkg::*;

  item_t                mem_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_BITS-1:0] count_q, count_d;

  assign stat_o.full  = (count_q == QCNT_BITS'(QUEUE_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign item_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// File: sv/dtv_back.sv
// ----------------------------------------------------------------------------
// dtv_back: voice rendering sequencer
// Pops one item at a time and renders it through a shared 32x32 multiplier,
// with the attack divide done by reciprocal in two halves; holds the voice
// state and output register.
// ----------------------------------------------------------------------------
module dtv_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dtv_pkg::cfg_t        cfg_i,
  input  dtv_pkg::item_t       item_i,
  input  dtv_pkg::queue_stat_t stat_i,
  output logic                 pop_o,
  dtv_sample_if.source         sample_out
);
  import dtv_pkg::*;

  seq_state_e state_q, state_d;
  seq_state_e ret_q, ret_d;

  logic [COUNT_BITS-1:0] count_q, count_d;
  logic [31:0]           kick_phase_q, kick_phase_d;
  logic [31:0]           tone_phase_q, tone_phase_d;
  logic [23:0]           amp_q, amp_d;
  logic [23:0]           sweep_q, sweep_d;
  logic                  out_valid_q, out_valid_d;

  item_t                     item_q, item_d;
  logic signed [63:0]        prod_q;
  logic signed [31:0]        mul_a, mul_b;
  logic [31:0]               ph_q, ph_d;
  logic [14:0]               z_q, z_d;
  logic [14:0]               x2_q, x2_d;
  logic [1:0]                quad_q, quad_d;
  logic signed [15:0]        sine_q, sine_d;
  logic signed [15:0]        sine0_q, sine0_d;
  logic signed [15:0]        oct_q, oct_d;
  logic signed [17:0]        osc_q, osc_d;
  logic [23:0]               env_q, env_d;
  logic [20:0]               gain_q, gain_d;
  logic [19:0]               omix_q, omix_d;
  logic signed [39:0]        sum_q, sum_d;
  logic signed [19:0]        left_q, left_d;
  logic [16:0]               atk_hi_q, atk_hi_d;
  logic [15:0]               atk_lo_q, atk_lo_d;
  logic [8:0]                atk_q1_q, atk_q1_d;
  logic signed [15:0]        res_left_q, res_left_d;
  logic signed [15:0]        res_right_q, res_right_d;
  logic signed [15:0]        out_left_q, out_left_d;
  logic signed [15:0]        out_right_q, out_right_d;

  logic [10:0] rev_sat, abst_sat, inv_rev;
  logic [19:0] saw_mix;
  logic [21:0] omix_num;
  logic [23:0] gain_num;
  logic        out_free;
  logic        need_attack;

  // sine front end
  logic [15:0] sin_u;
  logic [14:0] sin_z;
  // attack divide: remainder of the high half
  logic [8:0]  atk_rem;
  // mix and scale helpers
  logic signed [16:0] saw;
  logic signed [39:0] tone_sum;
  logic signed [25:0] scaled;
  logic [25:0]        biased;
  logic [14:0]        hash;
  logic [14:0]        sin_t1, sin_t;
  logic [15:0]        sin_y;
  logic [14:0]        sin_mag;

  assign rev_sat  = (cfg_i.reverence > 11'(LEVEL_ONE)) ? 11'(LEVEL_ONE) : cfg_i.reverence;
  assign abst_sat = (cfg_i.abstraction > 11'(LEVEL_ONE)) ? 11'(LEVEL_ONE)
                                                           : cfg_i.abstraction;
  assign inv_rev  = 11'(LEVEL_ONE) - rev_sat;
  assign saw_mix  = 20'(inv_rev) * 20'd768;
  assign omix_num = 22'(abst_sat) * 22'd2816;
  assign gain_num = 24'(inv_rev) * 24'd7168 + 24'(abst_sat) * 24'd256;

  assign out_free    = !out_valid_q || sample_out.ready;
  assign need_attack = (item_q.voice != VOICE_HAT) &&
                       (count_q < COUNT_BITS'(ATTACK_LEN));

  assign sin_u = ph_q[31:16] & SINE_MASK;
  assign sin_z = sin_u[14] ? (15'd16384 - {1'b0, sin_u[13:0]}) : {1'b0, sin_u[13:0]};

  assign atk_rem = 9'(atk_hi_q - prod_q[16:0]);

  assign saw      = $signed({1'b0, tone_phase_q[31:16]}) - 17'sd32768;
  assign tone_sum = sum_q + $signed(prod_q[39:0]);
  assign scaled   = $signed(prod_q[50:25]);
  assign biased   = 26'(scaled + DIV127_BIAS);
  assign hash     = 15'(prod_q[14:0] + HASH_ADD);
  assign sin_t1   = 15'd10512 - 15'(prod_q[24:14]);
  assign sin_t    = 15'd25736 - 15'(prod_q[27:14]);
  assign sin_y    = {prod_q[28:14], 1'b0};
  assign sin_mag  = (sin_y > 16'd32767) ? 15'h7FFF : sin_y[14:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:       if (!stat_i.empty) state_d = ST_GAIN_MUL;
      ST_GAIN_MUL:   state_d = ST_GAIN_SET;
      ST_GAIN_SET: begin
        case (item_q.voice)
          VOICE_KICK: state_d = ST_KICK_MUL;
          VOICE_HAT:  state_d = ST_HAT_MUL;
          default:    state_d = ST_TONE_MIX;
        endcase
      end
      ST_KICK_MUL:   state_d = ST_KICK_PHASE;
      ST_KICK_PHASE: state_d = ST_SIN_SQ;
      ST_KICK_OSC:   state_d = ST_SWEEP_SET;
      ST_SWEEP_SET:  state_d = ST_AMP_MUL;
      ST_HAT_MUL:    state_d = ST_HAT_OSC;
      ST_HAT_OSC:    state_d = ST_AMP_MUL;
      ST_TONE_MIX:   state_d = ST_TONE_SINE;
      ST_TONE_SINE:  state_d = ST_SIN_SQ;
      ST_TONE_OCT:   state_d = ST_SIN_SQ;
      ST_TONE_SUM0:  state_d = ST_TONE_SUM1;
      ST_TONE_SUM1:  state_d = ST_TONE_SUM2;
      ST_TONE_SUM2:  state_d = ST_TONE_SUM3;
      ST_TONE_SUM3:  state_d = ST_AMP_MUL;
      ST_SIN_SQ:     state_d = ST_SIN_T1;
      ST_SIN_T1:     state_d = ST_SIN_T2;
      ST_SIN_T2:     state_d = ST_SIN_T3;
      ST_SIN_T3:     state_d = ST_SIN_Y;
      ST_SIN_Y:      state_d = ret_q;
      ST_AMP_MUL:    state_d = ST_AMP_SET;
      ST_AMP_SET:    state_d = need_attack ? ST_ATK_LOAD : ST_VEL_MUL;
      ST_ATK_LOAD:   state_d = ST_ATK_Q1;
      ST_ATK_Q1:     state_d = ST_ATK_LO;
      ST_ATK_LO:     state_d = ST_ATK_SET;
      ST_ATK_SET:    state_d = ST_VEL_MUL;
      ST_VEL_MUL:    state_d = ST_OSC_MUL;
      ST_OSC_MUL:    state_d = ST_DIV127;
      ST_DIV127:     state_d = ST_LEFT;
      ST_LEFT:       state_d = ST_RIGHT;
      ST_RIGHT:      state_d = ST_OUT;
      ST_OUT:        if (out_free) state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  // datapath and control outputs
  always_comb begin
    pop_o        = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    ret_d        = ret_q;
    item_d       = item_q;
    count_d      = count_q;
    kick_phase_d = kick_phase_q;
    tone_phase_d = tone_phase_q;
    amp_d        = amp_q;
    sweep_d      = sweep_q;
    ph_d         = ph_q;
    z_d          = z_q;
    x2_d         = x2_q;
    quad_d       = quad_q;
    sine_d       = sine_q;
    sine0_d      = sine0_q;
    oct_d        = oct_q;
    osc_d        = osc_q;
    env_d        = env_q;
    gain_d       = gain_q;
    omix_d       = omix_q;
    sum_d        = sum_q;
    left_d       = left_q;
    atk_hi_d     = atk_hi_q;
    atk_lo_d     = atk_lo_q;
    atk_q1_d     = atk_q1_q;
    res_left_d   = res_left_q;
    res_right_d  = res_right_q;
    out_left_d   = out_left_q;
    out_right_d  = out_right_q;
    out_valid_d  = out_valid_q && !sample_out.ready;

    unique case (state_q)
      ST_IDLE: begin
        if (!stat_i.empty) begin
          pop_o  = 1'b1;
          item_d = item_i;
          if (item_i.note_start) begin
            count_d      = '0;
            kick_phase_d = '0;
            tone_phase_d = '0;
            amp_d        = ENV_FULL;
            sweep_d      = ENV_FULL;
          end
        end
      end
      ST_GAIN_MUL: begin
        env_d = amp_q;
        mul_a = $signed(32'(gain_num));
        mul_b = $signed(32'(GAIN_RECIP));
      end
      ST_GAIN_SET: begin
        gain_d = 21'(1 << 20) - 21'(prod_q[46:28]);
      end
      ST_KICK_MUL: begin
        mul_a = $signed(32'(item_q.step));
        mul_b = $signed(32'(sweep_q));
      end
      ST_KICK_PHASE: begin
        kick_phase_d = kick_phase_q + prod_q[55:24];
        ph_d         = kick_phase_q + prod_q[55:24];
        ret_d        = ST_KICK_OSC;
      end
      ST_KICK_OSC: begin
        osc_d = 18'(sine_q);
        mul_a = $signed(32'(sweep_q));
        mul_b = $signed(32'(SWEEP_DECAY));
      end
      ST_SWEEP_SET: begin
        sweep_d = prod_q[47:24];
      end
      ST_HAT_MUL: begin
        mul_a = $signed(32'(count_q[14:0]));
        mul_b = $signed(32'(HASH_MUL_LO));
      end
      ST_HAT_OSC: begin
        osc_d = $signed({2'b00, hash, 1'b0}) - 18'sd32768;
      end
      ST_TONE_MIX: begin
        mul_a = $signed(32'(omix_num));
        mul_b = $signed(32'(OMIX_RECIP));
      end
      ST_TONE_SINE: begin
        omix_d = prod_q[45:26];
        ph_d   = tone_phase_q;
        ret_d  = ST_TONE_OCT;
      end
      ST_TONE_OCT: begin
        sine0_d = sine_q;
        ph_d    = {tone_phase_q[30:0], 1'b0};
        ret_d   = ST_TONE_SUM0;
      end
      ST_TONE_SUM0: begin
        oct_d = sine_q;
        mul_a = 32'(sine0_q);
        mul_b = $signed(32'(21'(1 << 20) - 21'(saw_mix)));
      end
      ST_TONE_SUM1: begin
        sum_d = $signed(prod_q[39:0]);
        mul_a = 32'(saw);
        mul_b = $signed(32'(saw_mix));
      end
      ST_TONE_SUM2: begin
        sum_d = tone_sum;
        mul_a = 32'(oct_q);
        mul_b = $signed(32'(omix_q));
      end
      ST_TONE_SUM3: begin
        osc_d        = tone_sum[37:20];
        tone_phase_d = tone_phase_q + 32'(item_q.step);
      end
      ST_SIN_SQ: begin
        z_d    = sin_z;
        quad_d = sin_u[15:14];
        mul_a  = $signed(32'(sin_z));
        mul_b  = $signed(32'(sin_z));
      end
      ST_SIN_T1: begin
        x2_d  = prod_q[28:14];
        mul_a = $signed(32'(prod_q[28:14]));
        mul_b = 32'sd1160;
      end
      ST_SIN_T2: begin
        mul_a = $signed(32'(x2_q));
        mul_b = $signed(32'(sin_t1));
      end
      ST_SIN_T3: begin
        mul_a = $signed(32'(z_q));
        mul_b = $signed(32'(sin_t));
      end
      ST_SIN_Y: begin
        sine_d = quad_q[1] ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
      end
      ST_AMP_MUL: begin
        mul_a = $signed(32'(amp_q));
        case (item_q.voice)
          VOICE_KICK: mul_b = $signed(32'(KICK_DECAY));
          VOICE_HAT:  mul_b = $signed(32'(HAT_DECAY));
          default:    mul_b = $signed(32'(cfg_i.tone_decay));
        endcase
      end
      ST_AMP_SET: begin
        amp_d = prod_q[47:24];
        mul_a = $signed(32'(env_q));
        mul_b = $signed(32'(count_q[ATTACK_BITS-1:0]));
      end
      ST_ATK_LOAD: begin
        // split env*count into a 17-bit high half and a 16-bit low half, divide the high one
        atk_hi_d = prod_q[32:16];
        atk_lo_d = prod_q[15:0];
        mul_a    = $signed(32'(prod_q[32:16]));
        mul_b    = $signed(32'(ATK_RECIP));
      end
      ST_ATK_Q1: begin
        atk_q1_d = prod_q[42:34];
        mul_a    = $signed(32'(prod_q[42:34]));
        mul_b    = 32'(ATTACK_LEN);
      end
      ST_ATK_LO: begin
        // carry the high-half remainder into the low half
        mul_a = $signed(32'({atk_rem, atk_lo_q}));
        mul_b = $signed(32'(ATK_RECIP));
      end
      ST_ATK_SET: begin
        env_d = {atk_q1_q[7:0], prod_q[49:34]};
      end
      ST_VEL_MUL: begin
        mul_a = $signed(32'(env_q));
        mul_b = $signed(32'(item_q.velocity));
      end
      ST_OSC_MUL: begin
        mul_a = 32'(osc_q);
        mul_b = $signed(32'(prod_q[30:0]));
      end
      ST_DIV127: begin
        // bias keeps the floored quotient on an unsigned reciprocal
        mul_a = $signed(32'(biased));
        mul_b = $signed(32'(DIV127_RECIP));
      end
      ST_LEFT: begin
        left_d = $signed(prod_q[52:33]) - 20'sd262144;
        mul_a  = $signed(32'(prod_q[52:33])) - 32'sd262144;
        mul_b  = $signed(32'(gain_q));
      end
      ST_RIGHT: begin
        res_left_d  = sat16(left_q);
        res_right_d = sat16($signed(prod_q[39:20]));
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_left_d  = res_left_q;
          out_right_d = res_right_q;
          if (count_q != '1) begin
            count_d = count_q + 1'b1;
          end
        end
      end
      default: begin
        pop_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      ret_q        <= ST_IDLE;
      count_q      <= '0;
      kick_phase_q <= '0;
      tone_phase_q <= '0;
      amp_q        <= ENV_FULL;
      sweep_q      <= ENV_FULL;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      ret_q        <= ret_d;
      count_q      <= count_d;
      kick_phase_q <= kick_phase_d;
      tone_phase_q <= tone_phase_d;
      amp_q        <= amp_d;
      sweep_q      <= sweep_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q      <= mul_a * mul_b;
    item_q      <= item_d;
    ph_q        <= ph_d;
    z_q         <= z_d;
    x2_q        <= x2_d;
    quad_q      <= quad_d;
    sine_q      <= sine_d;
    sine0_q     <= sine0_d;
    oct_q       <= oct_d;
    osc_q       <= osc_d;
    env_q       <= env_d;
    gain_q      <= gain_d;
    omix_q      <= omix_d;
    sum_q       <= sum_d;
    left_q      <= left_d;
    atk_hi_q    <= atk_hi_d;
    atk_lo_q    <= atk_lo_d;
    atk_q1_q    <= atk_q1_d;
    res_left_q  <= res_left_d;
    res_right_q <= res_right_d;
    out_left_q  <= out_left_d;
    out_right_q <= out_right_d;
  end

  assign sample_out.valid        = out_valid_q;
  assign sample_out.left_sample  = out_left_q;
  assign sample_out.right_sample = out_right_q;

endmodule

// File: sv/drum_and_tone_voice_synth_unit.sv
// ----------------------------------------------------------------------------
// drum_and_tone_voice_synth_unit: one-voice kick, hat and tone renderer
// Each tick renders a hat, kick or tone voice from queue pop to result, with a
// reciprocal divide added while the 441-sample attack runs.
// Ticks render one at a time, since they share the 32x32 multiplier; the next is
// popped once the result waits in the output register. Two ticks queue ahead.
// Reset: counter and phases zero, envelopes full scale, config at defaults.
// ----------------------------------------------------------------------------
module drum_and_tone_voice_synth_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  dtv_note_if.sink    note_in,
  dtv_sample_if.source sample_out
);
  import dtv_pkg::*;

  cfg_t        cfg_q, cfg_d;
  item_t       front_item, queue_item;
  queue_stat_t q_stat;
  logic        q_push, q_pop;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (reg_index_e'(cfg_index_i))
        REG_REVERENCE:   cfg_d.reverence   = cfg_data_i[10:0];
        REG_ABSTRACTION: cfg_d.abstraction = cfg_data_i[10:0];
        REG_TONE_DECAY:  cfg_d.tone_decay  = cfg_data_i;
        default:         cfg_d = cfg_q;  // drop unknown index
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reverence   <= '0;
      cfg_q.abstraction <= '0;
      cfg_q.tone_decay  <= TONE_DECAY_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  dtv_front u_front (
    .note_in (note_in),
    .stat_i  (q_stat),
    .push_o  (q_push),
    .item_o  (front_item)
  );

  dtv_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .item_i (front_item),
    .pop_i  (q_pop),
    .item_o (queue_item),
    .stat_o (q_stat)
  );

  dtv_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .item_i     (queue_item),
    .stat_i     (q_stat),
    .pop_o      (q_pop),
    .sample_out (sample_out)
  );

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_stat.full)
    else $error("queue push while full");

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_stat.empty)
    else $error("queue pop while empty");

  a_full_empty_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("queue full and empty together");

endmodule

// File: test/dtv_voice_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dtv_voice_checker: sample predictor and scoreboard for the voice synth
// Watches the note and sample channels and the config port, renders the
// expected stereo sample for each accepted note tick, and compares each
// accepted sample with the oldest pending one.
// ----------------------------------------------------------------------------
module dtv_voice_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  input  logic        note_valid_i,
  input  logic        note_ready_i,
  input  logic        note_start_i,
  input  logic [6:0]  pitch_i,
  input  logic [6:0]  velocity_i,
  input  logic        smp_valid_i,
  input  logic        smp_ready_i,
  input  logic [15:0] left_i,
  input  logic [15:0] right_i,
  output int          fail_count_o,
  output int          pending_o
);
  import dtv_pkg::*;

  localparam longint CountMax = (64'd1 << COUNT_BITS) - 1;

  logic [10:0] rev_q;
  logic [10:0] abs_q;
  logic [23:0] tdecay_q;
  logic [31:0] cnt_q;
  logic [31:0] kphase_q;
  logic [31:0] tphase_q;
  logic [23:0] amp_q;
  logic [23:0] sweep_q;
  logic [31:0] pending_left[$];
  logic [31:0] pending_right[$];
  int          fails;

  const logic [31:0] StepTab[12] = '{
    32'd815363807, 32'd863847866, 32'd915214890, 32'd969636443,
    32'd1027293983, 32'd1088380142, 32'd1153098581, 32'd1221665381,
    32'd1294309404, 32'd1371272980, 32'd1452813111, 32'd1539201885};

  assign fail_count_o = fails;
  assign pending_o    = pending_left.size();

  function automatic longint fdiv(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic longint sine_of(logic [31:0] ph);
    longint n, u, quad, z, x2, t, y;
    n    = (longint'(ph) * SINE_TABLE_DEPTH) >>> 32;
    u    = ((n * 65536) / SINE_TABLE_DEPTH) & 16'hFFFF;
    quad = u >>> 14;
    z    = u & 16'h3FFF;
    if (quad[0]) z = 16384 - z;
    x2 = (z * z) >>> 14;
    t  = 10512 - ((1160 * x2) >>> 14);
    t  = 25736 - ((x2 * t) >>> 14);
    y  = ((z * t) >>> 14) * 2;
    if (y > 32767) y = 32767;
    return (quad >= 2) ? -y : y;
  endfunction

  function automatic logic [23:0] decayed(logic [23:0] env, logic [23:0] f);
    longint p;
    p = (longint'(env) * longint'(f)) >>> 24;
    return p[23:0];
  endfunction

  task automatic render_sample(logic st, logic [6:0] p, logic [6:0] v);
    longint rev, ab, osc, env, lft, rgt, gain, smix, omix, saw;
    logic [31:0] step, h;
    logic        atk;
    atk  = 1'b1;
    rev  = (rev_q > LEVEL_ONE) ? LEVEL_ONE : rev_q;
    ab   = (abs_q > LEVEL_ONE) ? LEVEL_ONE : abs_q;
    if (st) begin
      cnt_q = 0; kphase_q = 0; tphase_q = 0; amp_q = ENV_FULL; sweep_q = ENV_FULL;
    end
    step = StepTab[p % 12] >> (10 - p / 12);
    env  = amp_q;
    if (p < 40) begin
      kphase_q += 32'((longint'(step) * sweep_q) >>> 24);
      osc      = sine_of(kphase_q);
      sweep_q  = decayed(sweep_q, SWEEP_DECAY);
      amp_q    = decayed(amp_q, KICK_DECAY);
    end else if (p == 42 || p == 44 || p == 46) begin
      h     = (cnt_q * 32'd1103515245 + 32'd12345) & 32'h7FFF;
      osc   = longint'(h) * 2 - 32768;
      atk   = 1'b0;
      amp_q = decayed(amp_q, HAT_DECAY);
    end else begin
      smix = (1024 - rev) * 768;
      omix = (ab * 11264) / 20;
      saw  = longint'(tphase_q >> 16) - 32768;
      osc  = fdiv(sine_of(tphase_q) * (1048576 - smix) + saw * smix
                  + sine_of(tphase_q << 1) * omix, 1048576);
      tphase_q += step;
      amp_q = decayed(amp_q, tdecay_q);
    end
    if (atk && cnt_q < ATTACK_LEN) env = env * cnt_q / ATTACK_LEN;
    lft  = fdiv(osc * env * longint'(v), longint'(127) * 33554432);
    gain = 1048576 - ((1024 - rev) * 28672 + ab * 1024) / 100;
    rgt  = fdiv(lft * gain, 1048576);
    if (lft > 32767) lft = 32767;
    if (lft < -32768) lft = -32768;
    if (rgt > 32767) rgt = 32767;
    if (rgt < -32768) rgt = -32768;
    if (cnt_q < CountMax) cnt_q++;
    pending_left  = {pending_left, 32'(lft)};
    pending_right = {pending_right, 32'(rgt)};
  endtask

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what,
             $signed(got), $signed(want), $realtime);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic [31:0] el, er;
    if (!rst_ni) begin
      rev_q <= '0; abs_q <= '0; tdecay_q <= TONE_DECAY_RESET;
      cnt_q = 0; kphase_q = 0; tphase_q = 0; amp_q = ENV_FULL; sweep_q = ENV_FULL;
      fails = 0;
      pending_left.delete(); pending_right.delete();
    end else begin
      if (smp_valid_i && smp_ready_i) begin
        if (pending_left.size() == 0) begin
          report_mismatch("unexpected sample", left_i, 16'd0);
        end else begin
          el = pending_left.pop_front();
          er = pending_right.pop_front();
          if (left_i != el[15:0]) report_mismatch("left", left_i, el[15:0]);
          if (right_i != er[15:0]) report_mismatch("right", right_i, er[15:0]);
        end
      end
      if (note_valid_i && note_ready_i) render_sample(note_start_i, pitch_i, velocity_i);
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_REVERENCE:   rev_q <= cfg_data_i[10:0];
          REG_ABSTRACTION: abs_q <= cfg_data_i[10:0];
          REG_TONE_DECAY:  tdecay_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end
endmodule

// File: test/tb_drum_and_tone_voice_synth_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_drum_and_tone_voice_synth_unit: random note-tick test of the voice synth
// Drives directed and random note sequences (kick, hat, tone, pitch changes,
// counter runs) through several register settings with random idling on
// both channels; the checker predicts and compares every sample.
// ----------------------------------------------------------------------------
module tb_drum_and_tone_voice_synth_unit;
  import dtv_pkg::*;

  localparam int IdleLimit = 2000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = REG_REVERENCE;
  logic [23:0] cfg_data_i = '0;
  logic        calm = 1'b0;
  int          fail_count;
  int          pending;
  int          idle_cycles = 0;

  dtv_note_if   note_ch();
  dtv_sample_if smp_ch();

  initial begin
    note_ch.valid = 1'b0; note_ch.note_start = 1'b0;
    note_ch.pitch = '0; note_ch.velocity = '0;
    smp_ch.ready = 1'b0;
  end

  drum_and_tone_voice_synth_unit dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .note_in(note_ch), .sample_out(smp_ch)
  );

  dtv_voice_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .note_valid_i(note_ch.valid), .note_ready_i(note_ch.ready),
    .note_start_i(note_ch.note_start), .pitch_i(note_ch.pitch),
    .velocity_i(note_ch.velocity),
    .smp_valid_i(smp_ch.valid), .smp_ready_i(smp_ch.ready),
    .left_i(smp_ch.left_sample), .right_i(smp_ch.right_sample),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // sink side: stall in random bursts unless the run is calm
  always @(posedge clk_i) begin
    int stall;
    if (!rst_ni || calm) begin
      smp_ch.ready <= rst_ni;
    end else if ($urandom_range(0, 5) == 0) begin
      stall = $urandom_range(1, 6);
      smp_ch.ready <= 1'b0;
      repeat (stall) @(posedge clk_i);
      smp_ch.ready <= 1'b1;
    end else begin
      smp_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((note_ch.valid && note_ch.ready) || (smp_ch.valid && smp_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // valid stays high across back-to-back ticks; drain_samples drops it
  task automatic send_tick(logic st, logic [6:0] p, logic [6:0] v);
    if (!calm && $urandom_range(0, 4) == 0) begin
      note_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    note_ch.valid      <= 1'b1;
    note_ch.note_start <= st;
    note_ch.pitch      <= p;
    note_ch.velocity   <= v;
    do @(posedge clk_i); while (!note_ch.ready);
  endtask

  task automatic drain_samples();
    note_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (70) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_index_e idx, logic [23:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [6:0] pick_pitch();
    case ($urandom_range(0, 3))
      0: return 7'($urandom_range(0, 39));
      1: return 7'(42 + 2 * $urandom_range(0, 2));
      2: return 7'($urandom_range(0, 127));
      default: return 7'($urandom_range(40, 127));
    endcase
  endfunction

  // well-formed notes: a start tick then a run on one pitch, some pitch changes
  task automatic play_notes(int n_ticks);
    int          left_in_note;
    logic [6:0]  p;
    logic [6:0]  v;
    left_in_note = 0;
    p = 0;
    v = 0;
    repeat (n_ticks) begin
      if (left_in_note == 0) begin
        p = pick_pitch();
        v = 7'($urandom_range(0, 127));
        left_in_note = $urandom_range(1, 120);
        send_tick(1'b1, p, v);
      end else if ($urandom_range(0, 19) == 0) begin
        send_tick(1'($urandom), 7'($urandom), 7'($urandom));
      end else begin
        send_tick(1'b0, p, v);
      end
      left_in_note--;
    end
  endtask

  initial begin
    logic [6:0] dir_pitch[10] = '{0, 39, 40, 41, 42, 44, 46, 60, 127, 45};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: each voice, field extremes, pitch change mid-note
    foreach (dir_pitch[k]) begin
      send_tick(1'b1, dir_pitch[k], 7'd127);
      send_tick(1'b0, dir_pitch[k], 7'd0);
    end
    send_tick(1'b0, 7'd30, 7'd127);
    send_tick(1'b0, 7'd44, 7'd64);
    send_tick(1'b0, 7'd100, 7'd1);
    drain_samples();

    // levels above one, unknown index ignored
    write_reg(REG_REVERENCE, 24'h7FF);
    write_reg(REG_ABSTRACTION, 24'h7FF);
    write_reg(REG_TONE_DECAY, 24'hFFFFFF);
    write_reg(reg_index_e'(2'd3), 24'hABCDEF);
    send_tick(1'b1, 7'd69, 7'd127);
    send_tick(1'b0, 7'd20, 7'd127);
    send_tick(1'b0, 7'd46, 7'd127);
    drain_samples();

    repeat (4) begin
      write_reg(REG_REVERENCE, 24'($urandom_range(0, 2047)));
      write_reg(REG_ABSTRACTION, 24'($urandom_range(0, 2047)));
      write_reg(REG_TONE_DECAY, ($urandom_range(0, 1)) ? 24'($urandom) : 24'd16700000);
      play_notes(240);
      drain_samples();
    end

    write_reg(REG_REVERENCE, 24'd0);
    write_reg(REG_ABSTRACTION, 24'd1024);
    write_reg(REG_TONE_DECAY, 24'd0);
    calm <= 1'b1;
    play_notes(300);
    drain_samples();

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
